>>> hw/rtl/evr_pkg.sv
// Shared constants, operation codes and types for the elementwise vector reducer.
`timescale 1ns / 1ps

package evr_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ELEMENTS  = 1024;
  localparam int MAX_PRODUCERS = 64;
  localparam int ADDR_W        = $clog2(MAX_ELEMENTS);
  localparam int PROD_W        = $clog2(MAX_PRODUCERS);
  localparam int LEN_W         = 11;
  localparam int CNT_W         = 7;
  localparam int OP_W          = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 11;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SUM    = 3'd0;
  localparam logic [OP_W-1:0] OP_PROD   = 3'd1;
  localparam logic [OP_W-1:0] OP_MAX    = 3'd2;
  localparam logic [OP_W-1:0] OP_MIN    = 3'd3;
  localparam logic [OP_W-1:0] OP_MINMAX = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_OP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCER_COUNT = 2'd2;

  // Per-item control carried from the sequencer into the combine stage
  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    logic              first;
    logic              last_elem;
    logic              last_prod;
    logic [OP_W-1:0]   op;
  } evr_item_t;

endpackage

>>> hw/rtl/evr_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module evr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/evr_seq.sv
// Configuration registers and element/producer counters that tag each item.
`timescale 1ns / 1ps

module evr_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [evr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [evr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              advance,
  output evr_pkg::evr_item_t                item
);

  logic [evr_pkg::OP_W-1:0]   reduce_op_r;
  logic [evr_pkg::LEN_W-1:0]  vector_length_r;
  logic [evr_pkg::CNT_W-1:0]  producer_count_r;
  logic [evr_pkg::ADDR_W-1:0] elem_cnt_r, elem_cnt_nxt;
  logic [evr_pkg::PROD_W-1:0] prod_cnt_r, prod_cnt_nxt;
  logic [evr_pkg::LEN_W-1:0]  len_eff;
  logic [evr_pkg::CNT_W-1:0]  cnt_eff;
  logic [evr_pkg::LEN_W-1:0]  elem_next;
  logic [evr_pkg::CNT_W-1:0]  prod_next;
  logic                       last_elem;
  logic                       last_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reduce_op_r      <= evr_pkg::OP_SUM;
      vector_length_r  <= evr_pkg::LEN_W'(1);
      producer_count_r <= evr_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        evr_pkg::REG_REDUCE_OP:      reduce_op_r <= cfg_wdata[evr_pkg::OP_W-1:0];
        evr_pkg::REG_VECTOR_LENGTH:  vector_length_r <= cfg_wdata[evr_pkg::LEN_W-1:0];
        evr_pkg::REG_PRODUCER_COUNT: producer_count_r <= cfg_wdata[evr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the configured extents into their legal ranges
  always_comb begin
    if (vector_length_r == '0) begin
      len_eff = evr_pkg::LEN_W'(1);
    end else if (vector_length_r > evr_pkg::LEN_W'(evr_pkg::MAX_ELEMENTS)) begin
      len_eff = evr_pkg::LEN_W'(evr_pkg::MAX_ELEMENTS);
    end else begin
      len_eff = vector_length_r;
    end
    if (producer_count_r == '0) begin
      cnt_eff = evr_pkg::CNT_W'(1);
    end else if (producer_count_r > evr_pkg::CNT_W'(evr_pkg::MAX_PRODUCERS)) begin
      cnt_eff = evr_pkg::CNT_W'(evr_pkg::MAX_PRODUCERS);
    end else begin
      cnt_eff = producer_count_r;
    end
  end

  assign elem_next = evr_pkg::LEN_W'(elem_cnt_r) + evr_pkg::LEN_W'(1);
  assign prod_next = evr_pkg::CNT_W'(prod_cnt_r) + evr_pkg::CNT_W'(1);
  assign last_elem = elem_next >= len_eff;
  assign last_prod = prod_next >= cnt_eff;

  always_comb begin
    elem_cnt_nxt = elem_cnt_r;
    prod_cnt_nxt = prod_cnt_r;
    if (advance) begin
      if (last_elem) begin
        elem_cnt_nxt = '0;
        prod_cnt_nxt = last_prod ? '0 : prod_next[evr_pkg::PROD_W-1:0];
      end else begin
        elem_cnt_nxt = elem_next[evr_pkg::ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r <= '0;
      prod_cnt_r <= '0;
    end else begin
      elem_cnt_r <= elem_cnt_nxt;
      prod_cnt_r <= prod_cnt_nxt;
    end
  end

  always_comb begin
    item.idx       = elem_cnt_r;
    item.first     = (prod_cnt_r == '0);
    item.last_elem = last_elem;
    item.last_prod = last_prod;
    // unknown codes act as sum
    item.op        = (reduce_op_r > evr_pkg::OP_MINMAX) ? evr_pkg::OP_SUM : reduce_op_r;
  end

endmodule

>>> hw/rtl/evr_alu.sv
// Combine unit: merges an element into the stored accumulator pair.
`timescale 1ns / 1ps

module evr_alu (
  input  logic [evr_pkg::OP_W-1:0]          op,
  input  logic                              first,
  input  logic signed [evr_pkg::DATA_W-1:0] x,
  input  logic signed [evr_pkg::DATA_W-1:0] acc,
  input  logic signed [evr_pkg::DATA_W-1:0] mx,
  output logic signed [evr_pkg::DATA_W-1:0] acc_out,
  output logic signed [evr_pkg::DATA_W-1:0] mx_out
);

  logic [evr_pkg::DATA_W-1:0] prod;

  assign prod = evr_pkg::DATA_W'(acc * x);

  always_comb begin
    acc_out = acc;
    mx_out  = mx;
    if (first) begin
      acc_out = x;
      mx_out  = x;
    end else begin
      case (op)
        evr_pkg::OP_PROD: acc_out = $signed(prod);
        evr_pkg::OP_MAX:  if (acc < x) acc_out = x;
        evr_pkg::OP_MIN:  if (x < acc) acc_out = x;
        evr_pkg::OP_MINMAX: begin
          if (x < acc) acc_out = x;
          if (mx < x) mx_out = x;
        end
        default: acc_out = acc + x;
      endcase
    end
  end

endmodule

>>> hw/rtl/elementwise_vector_reduce.sv
// Top level of the elementwise vector reducer: read stage, combine stage, result register.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  cfg     | cfg_valid/ready, cfg_index, cfg_data   | in
//  in      | in_valid/ready, in_element_value       | in
//  out     | out_valid/ready, out_reduced_value,    | out
//          | out_max_value, out_element_index,      |
//          | out_last_element                       |
//
// One item per cycle unless stalled; a result passes the combine and result registers. The
// accumulator RAMs are read on acceptance and written back from the combine stage; a write
// landing on the address read in the same cycle is forwarded from a register. rst_n clears
// counters, configuration and valids; the RAMs are not cleared. A waiting result stalls
// the combine stage only when that stage also has a result.
`timescale 1ns / 1ps

module elementwise_vector_reduce (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [evr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [evr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [evr_pkg::DATA_W-1:0]   in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [evr_pkg::DATA_W-1:0]   out_reduced_value,
  output logic signed [evr_pkg::DATA_W-1:0]   out_max_value,
  output logic [evr_pkg::ADDR_W-1:0]          out_element_index,
  output logic                                out_last_element
);

  evr_pkg::evr_item_t               item0;
  evr_pkg::evr_item_t               s1_item_r;
  logic                             s1_valid_r;
  logic signed [evr_pkg::DATA_W-1:0] s1_x_r;
  logic                             accept;
  logic                             s1_adv;
  logic                             wr_en;
  logic [evr_pkg::DATA_W-1:0]       acc_rd, mx_rd;
  logic signed [evr_pkg::DATA_W-1:0] acc_in, mx_in, acc_new, mx_new;
  logic                             fwd_hit_r;
  logic signed [evr_pkg::DATA_W-1:0] fwd_acc_r, fwd_mx_r;
  logic                             out_load;
  logic                             out_valid_r;
  logic signed [evr_pkg::DATA_W-1:0] out_red_r, out_max_r;
  logic [evr_pkg::ADDR_W-1:0]       out_idx_r;
  logic                             out_last_r;

  assign cfg_ready = 1'b1;

  // combine stage moves unless it holds a result and the result register is blocked
  assign s1_adv   = !s1_item_r.last_prod || !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign wr_en    = s1_valid_r && s1_adv;
  assign out_load = wr_en && s1_item_r.last_prod;

  evr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .advance   (accept),
    .item      (item0)
  );

  evr_ram #(.DEPTH(evr_pkg::MAX_ELEMENTS), .WIDTH(evr_pkg::DATA_W)) u_acc_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_item_r.idx),
    .wdata (acc_new),
    .re    (accept),
    .raddr (item0.idx),
    .rdata (acc_rd)
  );

  evr_ram #(.DEPTH(evr_pkg::MAX_ELEMENTS), .WIDTH(evr_pkg::DATA_W)) u_max_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_item_r.idx),
    .wdata (mx_new),
    .re    (accept),
    .raddr (item0.idx),
    .rdata (mx_rd)
  );

  // capture a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (accept) begin
      fwd_hit_r <= wr_en && (s1_item_r.idx == item0.idx);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_acc_r <= acc_new;
      fwd_mx_r  <= mx_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item0;
      s1_x_r    <= in_element_value;
    end
  end

  assign acc_in = fwd_hit_r ? fwd_acc_r : $signed(acc_rd);
  assign mx_in  = fwd_hit_r ? fwd_mx_r  : $signed(mx_rd);

  evr_alu u_alu (
    .op      (s1_item_r.op),
    .first   (s1_item_r.first),
    .x       (s1_x_r),
    .acc     (acc_in),
    .mx      (mx_in),
    .acc_out (acc_new),
    .mx_out  (mx_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r  <= acc_new;
      out_max_r  <= (s1_item_r.op == evr_pkg::OP_MINMAX) ? mx_new : '0;
      out_idx_r  <= s1_item_r.idx;
      out_last_r <= s1_item_r.last_elem;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reduced_value = out_red_r;
  assign out_max_value     = out_max_r;
  assign out_element_index = out_idx_r;
  assign out_last_element  = out_last_r;

endmodule

>>> tb/tb_elementwise_vector_reduce.sv
// Self-checking testbench for the elementwise vector reducer: stimulus, prediction, checks.
`timescale 1ns / 1ps

import evr_pkg::*;

// One reduced element as it leaves the block
typedef struct packed {
  logic signed [DATA_W-1:0] reduced;
  logic signed [DATA_W-1:0] peak;
  logic [ADDR_W-1:0]        index;
  logic                     last;
} reduction_t;

function automatic int clip_to(input int v, input int hi);
  return (v < 1) ? 1 : ((v > hi) ? hi : v);
endfunction

// Tracks the reducer's registers, counters and accumulators, and queues the reductions due
class reduction_tracker;
  logic [OP_W-1:0]          op_reg;
  logic [LEN_W-1:0]         len_reg;
  logic [CNT_W-1:0]         cnt_reg;
  logic signed [DATA_W-1:0] acc_mem [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] peak_mem [MAX_ELEMENTS];
  int                       elem_ctr;
  int                       prod_ctr;
  int                       filled;
  int                       mismatches;
  reduction_t               awaited [$];

  function new();
    op_reg     = OP_SUM;
    len_reg    = LEN_W'(1);
    cnt_reg    = CNT_W'(1);
    elem_ctr   = 0;
    prod_ctr   = 0;
    filled     = 0;
    mismatches = 0;
  endfunction

  function void take_config(input logic [CFG_IDX_W-1:0] index,
                            input logic [CFG_DATA_W-1:0] value);
    case (index)
      REG_REDUCE_OP:      op_reg  = value[OP_W-1:0];
      REG_VECTOR_LENGTH:  len_reg = value[LEN_W-1:0];
      REG_PRODUCER_COUNT: cnt_reg = value[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_element(input logic signed [DATA_W-1:0] x);
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] peak;
    bit                       end_vec;
    bit                       end_pass;
    reduction_t               due;
    // codes above min-and-max fall back to sum
    op = (op_reg > OP_MINMAX) ? OP_SUM : op_reg;
    if (prod_ctr == 0) begin
      acc  = x;
      peak = x;
    end else begin
      acc  = acc_mem[elem_ctr];
      peak = peak_mem[elem_ctr];
      case (op)
        OP_PROD: acc = acc * x;
        OP_MAX:  if (x > acc) acc = x;
        OP_MIN:  if (x < acc) acc = x;
        OP_MINMAX: begin
          if (x < acc) acc = x;
          if (x > peak) peak = x;
        end
        default: acc = acc + x;
      endcase
    end
    acc_mem[elem_ctr]  = acc;
    peak_mem[elem_ctr] = peak;
    if (elem_ctr >= filled) filled = elem_ctr + 1;
    end_vec  = (elem_ctr + 1) >= clip_to(int'(len_reg), MAX_ELEMENTS);
    end_pass = (prod_ctr + 1) >= clip_to(int'(cnt_reg), MAX_PRODUCERS);
    if (end_pass) begin
      due.reduced = acc;
      due.peak    = (op == OP_MINMAX) ? peak : '0;
      due.index   = ADDR_W'(elem_ctr);
      due.last    = end_vec;
      awaited.push_back(due);
    end
    if (end_vec) begin
      elem_ctr = 0;
      prod_ctr = end_pass ? 0 : prod_ctr + 1;
    end else begin
      elem_ctr++;
    end
  endfunction

  function void flag(input string field, input logic [DATA_W-1:0] want,
                     input logic [DATA_W-1:0] got);
    mismatches++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
  endfunction

  function void check_result(input reduction_t got);
    reduction_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: expected none, actual reduced %h max %h index %0d last %0d",
               $time, got.reduced, got.peak, got.index, got.last);
      return;
    end
    want = awaited.pop_front();
    if (got.reduced !== want.reduced) flag("reduced_value", want.reduced, got.reduced);
    if (got.peak !== want.peak) flag("max_value", want.peak, got.peak);
    if (got.index !== want.index) flag("element_index", DATA_W'(want.index), DATA_W'(got.index));
    if (got.last !== want.last) flag("last_element", DATA_W'(want.last), DATA_W'(got.last));
  endfunction
endclass

module tb_elementwise_vector_reduce;

  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 12;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_ITEMS     = 320;
  localparam int RANDOM_ITEMS   = 550;

  localparam logic [OP_W-1:0]      OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0]      OP_UNDEF_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [DATA_W-1:0]     in_element_value;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [DATA_W-1:0]     out_reduced_value;
  logic signed [DATA_W-1:0]     out_max_value;
  logic [ADDR_W-1:0]            out_element_index;
  logic                         out_last_element;

  reduction_tracker tracker = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int quiet_cycles = 0;

  elementwise_vector_reduce dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reduced_value (out_reduced_value),
    .out_max_value     (out_max_value),
    .out_element_index (out_element_index),
    .out_last_element  (out_last_element)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check each item taken, then decide ready for the next cycle
  initial begin : result_sink
    int         stall_left;
    int         hold_left;
    int         holds_served;
    reduction_t seen;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    out_ready    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        seen.reduced = out_reduced_value;
        seen.peak    = out_max_value;
        seen.index   = out_element_index;
        seen.last    = out_last_element;
        tracker.check_result(seen);
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return MOST_POSITIVE;
      1:       return MOST_NEGATIVE;
      2:       return '0;
      3:       return '1;
      4, 5:    return DATA_W'(int'($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.take_config(index, value);
  endtask

  task automatic configure(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                           input logic [CNT_W-1:0] cnt);
    write_reg(REG_REDUCE_OP, CFG_DATA_W'(op));
    write_reg(REG_VECTOR_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_PRODUCER_COUNT, CFG_DATA_W'(cnt));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline empty
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic feed(input logic signed [DATA_W-1:0] v);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_element(v);
  endtask

  task automatic random_phase(input bit calm, output int sent);
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
    int               k;
    int               eff_len;
    int               eff_cnt;
    int               pass_items;
    bit               cut_short;
    k  = $urandom_range(15);
    op = OP_W'((k < 13) ? k % 5 : k - 8);
    k  = $urandom_range(19);
    if (k == 0) cnt = '0;
    else if (k == 1) cnt = CNT_W'(MAX_PRODUCERS);
    else if (k == 2) cnt = CNT_W'($urandom_range(65, 127));
    else cnt = CNT_W'($urandom_range(1, 5));
    k = $urandom_range(19);
    if (k == 0) len = '0;
    else if (k == 1) len = LEN_W'($urandom_range(9, 40));
    else len = LEN_W'($urandom_range(1, 6));
    if (clip_to(int'(cnt), MAX_PRODUCERS) > 8) len = LEN_W'($urandom_range(1, 2));
    // a long vector abandoned part way, so the next setting starts mid-vector
    cut_short = ($urandom_range(7) == 0);
    if (cut_short) begin
      len = $urandom_range(1) ? LEN_W'(MAX_ELEMENTS) : '1;
      cnt = CNT_W'(1);
    end
    // mid-pass, never reach past the entries written so far
    if (tracker.prod_ctr != 0 && clip_to(int'(len), MAX_ELEMENTS) > tracker.filled)
      len = LEN_W'(tracker.filled);
    eff_len    = clip_to(int'(len), MAX_ELEMENTS);
    eff_cnt    = clip_to(int'(cnt), MAX_PRODUCERS);
    pass_items = eff_len * eff_cnt;
    if (cut_short) begin
      sent = $urandom_range(20, 120);
    end else begin
      sent = pass_items * ((pass_items > 40) ? 1 : $urandom_range(1, 3));
      if ($urandom_range(3) == 0) sent += $urandom_range(0, pass_items - 1);
    end
    settle(SETTLE_CYCLES);
    tx_idle_pct = calm ? 0 : 20 * $urandom_range(2);
    rx_idle_pct = calm ? 0 : 20 * $urandom_range(2);
    configure(op, len, cnt);
    repeat (sent) feed(pick_value());
  endtask

  initial begin : stimulus
    int random_items;
    int sent;
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_element_value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: sum of a single one-element vector
    feed(MOST_POSITIVE);
    feed(MOST_NEGATIVE);
    settle(SETTLE_CYCLES);
    configure(OP_SUM, LEN_W'(2), CNT_W'(2));
    feed(MOST_POSITIVE); feed(1); feed(1); feed(-1);
    settle(SETTLE_CYCLES);
    configure(OP_PROD, LEN_W'(1), CNT_W'(3));
    feed(32'sh0001_0001); feed(32'sh0001_0001); feed(3);
    settle(SETTLE_CYCLES);
    configure(OP_MAX, LEN_W'(1), CNT_W'(2));
    feed(MOST_NEGATIVE); feed(MOST_POSITIVE);
    settle(SETTLE_CYCLES);
    configure(OP_MIN, LEN_W'(1), CNT_W'(2));
    feed(MOST_POSITIVE); feed(MOST_NEGATIVE);
    settle(SETTLE_CYCLES);
    configure(OP_MINMAX, LEN_W'(2), CNT_W'(2));
    feed(5); feed(-7); feed(-3); feed(9);
    // unknown operations act as sum; zero length and zero count act as one
    settle(SETTLE_CYCLES);
    configure(OP_UNDEF_LO, '0, CNT_W'(2));
    feed(3); feed(4);
    settle(SETTLE_CYCLES);
    write_reg(REG_UNUSED, '1);
    configure(OP_UNDEF_HI, '0, '0);
    feed(MOST_NEGATIVE);

    // hold the result side off while items keep coming, then pause until drained
    settle(SETTLE_CYCLES);
    configure(OP_SUM, LEN_W'(3), CNT_W'(1));
    hold_requests++;
    repeat (30) feed(pick_value());
    settle(0);
    repeat (30) feed(pick_value());

    // long vector written as the oversized length, abandoned part way
    settle(SETTLE_CYCLES);
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    configure(OP_W'($urandom_range(4)), '1, CNT_W'(1));
    repeat (LONG_ITEMS) feed(pick_value());

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      random_phase(random_items > RANDOM_ITEMS - 150, sent);
      random_items += sent;
    end

    settle(TAIL_CYCLES);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
